@@ rtl/qfa_pkg.sv @@
// Package with operation codes, widths and shared types for the Q24.8 ALU.
package qfa_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 8;
  localparam int MagBits  = WordBits;
  localparam int NumBits  = WordBits + FracBits;
  localparam int QuotBits = NumBits;
  localparam int MulBits  = 2 * WordBits;

  typedef enum logic [3:0] {
    OpAdd     = 4'd0,
    OpSub     = 4'd1,
    OpMul     = 4'd2,
    OpDiv     = 4'd3,
    OpGt      = 4'd4,
    OpLt      = 4'd5,
    OpGe      = 4'd6,
    OpLe      = 4'd7,
    OpEq      = 4'd8,
    OpNe      = 4'd9,
    OpMin     = 4'd10,
    OpMax     = 4'd11,
    OpInc     = 4'd12,
    OpDec     = 4'd13,
    OpToInt   = 4'd14,
    OpFromInt = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StOverflow = 2'd1,
    StDivZero  = 2'd2
  } status_e;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic                         valid;
    logic                         div_op;
    logic                         neg;
    logic [MagBits:0]             rem;
    logic [NumBits-1:0]           num;
    logic [QuotBits-1:0]          quot;
    logic [MagBits-1:0]           den;
    logic [WordBits-1:0]          value;
    logic                         cmp;
    status_e                      status;
  } qfa_cell_t;

  function automatic logic [WordBits-1:0] sat_mag(input logic neg,
                                                 input logic [QuotBits:0] mag,
                                                 output logic ovf);
    logic [QuotBits:0] lim;
    begin
      lim = neg ? ({{(QuotBits+1-WordBits){1'b0}}, 1'b1, {(WordBits-1){1'b0}}})
                : ({{(QuotBits+2-WordBits){1'b0}}, {(WordBits-1){1'b1}}});
      ovf = mag > lim;
      if (ovf) begin
        sat_mag = neg ? {1'b1, {(WordBits-1){1'b0}}} : {1'b0, {(WordBits-1){1'b1}}};
      end else begin
        sat_mag = neg ? (~mag[WordBits-1:0] + 1'b1) : mag[WordBits-1:0];
      end
    end
  endfunction

endpackage

@@ rtl/q24_8_fixed_point_alu.sv @@
// Top level of the Q24.8 fixed-point ALU with a chain of divider cells.
//
//  channel | valid      | stall      | payload
//  input   | in_valid_i | in_stall_o | action_i, operand_a_i, operand_b_i
//  output  | out_valid_o| out_stall_i| result_value_o, compare_true_o, status_o
//
// One transaction enters each cycle unless the input is stalled. The result passes
// through the input register, 40 divider cells and the output register,
// with rounding done in front of the output register. Every operation walks the
// same chain so order is kept. Reset clears all valid bits. A stall on a valid output
// freezes the whole chain, and the input is stalled while it holds.
module q24_8_fixed_point_alu
  import qfa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [3:0]          action_i,
  input  logic signed [31:0]  operand_a_i,
  input  logic signed [31:0]  operand_b_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  result_value_o,
  output logic                compare_true_o,
  output logic [1:0]          status_o
);

  localparam logic [WordBits-1:0] MaxV = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic [WordBits-1:0] MinV = {1'b1, {(WordBits-1){1'b0}}};

  logic stall;
  assign stall      = out_valid_o && out_stall_i;
  assign in_stall_o = stall;

  op_e op;
  logic signed [WordBits:0] sum;
  logic signed [WordBits:0] dif;
  logic [MagBits-1:0] mag_a, mag_b;
  logic [MulBits-1:0] prod;
  qfa_cell_t head_d, head_q;
  logic signed [WordBits-1:0] hi_part;

  assign op    = op_e'(action_i);
  assign mag_a = operand_a_i[WordBits-1] ? (~operand_a_i + 1'b1) : operand_a_i;
  assign mag_b = operand_b_i[WordBits-1] ? (~operand_b_i + 1'b1) : operand_b_i;
  assign hi_part = operand_a_i >>> (WordBits - 1 - FracBits);

  always_comb begin
    head_d        = '0;
    head_d.valid  = in_valid_i;
    head_d.den    = mag_b;
    head_d.neg    = operand_a_i[WordBits-1] ^ operand_b_i[WordBits-1];
    head_d.status = StOk;
    sum = '0;
    dif = '0;
    prod = '0;
    case (op)
      OpAdd, OpInc: begin
        sum = {operand_a_i[WordBits-1], operand_a_i}
            + ((op == OpInc) ? (WordBits+1)'(1) : {operand_b_i[WordBits-1], operand_b_i});
        head_d.value = sum[WordBits-1:0];
        if (sum[WordBits] != sum[WordBits-1]) begin
          head_d.status = StOverflow;
          head_d.value  = sum[WordBits] ? MinV : MaxV;
        end
      end
      OpSub, OpDec: begin
        dif = {operand_a_i[WordBits-1], operand_a_i}
            - ((op == OpDec) ? (WordBits+1)'(1) : {operand_b_i[WordBits-1], operand_b_i});
        head_d.value = dif[WordBits-1:0];
        if (dif[WordBits] != dif[WordBits-1]) begin
          head_d.status = StOverflow;
          head_d.value  = dif[WordBits] ? MinV : MaxV;
        end
      end
      OpMul: begin
        // Product with rounding: numerator = |a*b| + half, divided by 2^F.
        // Fed through the chain as a divide by one of the pre-shifted sum.
        prod = mag_a * mag_b;
        head_d.div_op = 1'b1;
        head_d.den    = MagBits'(1);
        head_d.num    = NumBits'((prod + (MulBits'(1) << (FracBits - 1))) >> FracBits);
        head_d.value  = ((prod + (MulBits'(1) << (FracBits - 1))) >> FracBits) >>
                        NumBits == '0 ? '0 : MaxV;
        head_d.cmp    = |(((prod + (MulBits'(1) << (FracBits - 1))) >> FracBits) >> NumBits);
      end
      OpDiv: begin
        if (operand_b_i == '0) begin
          head_d.status = StDivZero;
        end else begin
          head_d.div_op = 1'b1;
          head_d.num    = {mag_a, {FracBits{1'b0}}};
        end
      end
      OpGt: head_d.cmp = operand_a_i >  operand_b_i;
      OpLt: head_d.cmp = operand_a_i <  operand_b_i;
      OpGe: head_d.cmp = operand_a_i >= operand_b_i;
      OpLe: head_d.cmp = operand_a_i <= operand_b_i;
      OpEq: head_d.cmp = operand_a_i == operand_b_i;
      OpNe: head_d.cmp = operand_a_i != operand_b_i;
      OpMin: head_d.value = (operand_a_i < operand_b_i) ? operand_a_i : operand_b_i;
      OpMax: head_d.value = (operand_a_i > operand_b_i) ? operand_a_i : operand_b_i;
      OpToInt: begin
        head_d.value = (operand_a_i[WordBits-1] && (|operand_a_i[FracBits-1:0]))
                     ? WordBits'((operand_a_i >>> FracBits) + 1)
                     : WordBits'(operand_a_i >>> FracBits);
      end
      OpFromInt: begin
        head_d.value = operand_a_i <<< FracBits;
        if (hi_part != '0 && hi_part != '1) begin
          head_d.status = StOverflow;
          head_d.value  = operand_a_i[WordBits-1] ? MinV : MaxV;
        end
      end
      default: head_d.value = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else if (!stall) begin
      head_q <= head_d;
    end
  end

  qfa_cell_t chain [0:QuotBits];
  assign chain[0] = head_q;

  for (genvar g = 0; g < QuotBits; g++) begin : g_cell
    qfa_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stall_i (stall),
      .cell_i  (chain[g]),
      .cell_o  (chain[g+1])
    );
  end

  qfa_cell_t tail;
  logic [QuotBits:0] qmag;
  logic [WordBits-1:0] div_val;
  logic div_ovf;
  logic round_up;
  logic val_q;
  logic [WordBits-1:0] res_q;
  logic cmp_q;
  status_e st_q;

  assign tail = chain[QuotBits];
  // For a true divide round half up on the remainder; for a product the
  // divisor is one so the remainder is zero and the flag carries a high word.
  assign round_up = (tail.rem >= ({1'b0, tail.den} - tail.rem)) && (tail.den != MagBits'(1));
  assign qmag = {1'b0, tail.quot} + (QuotBits+1)'(round_up);

  always_comb begin
    div_val = sat_mag(tail.neg, qmag, div_ovf);
    if (tail.den == MagBits'(1) && tail.cmp) begin
      div_ovf = 1'b1;
      div_val = tail.neg ? MinV : MaxV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= 1'b0;
    end else if (!stall) begin
      val_q <= tail.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      if (tail.div_op) begin
        res_q <= div_val;
        cmp_q <= 1'b0;
        st_q  <= div_ovf ? StOverflow : StOk;
      end else begin
        res_q <= tail.value;
        cmp_q <= tail.cmp;
        st_q  <= tail.status;
      end
    end
  end

  assign out_valid_o    = val_q;
  assign result_value_o = res_q;
  assign compare_true_o = cmp_q;
  assign status_o       = st_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(res_q) && val_q)
    else $error("result changed under stall");
  a_cmp_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    val_q && cmp_q |-> st_q == StOk && res_q == '0)
    else $error("comparison with nonzero result");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    val_q && st_q == StDivZero |-> res_q == '0)
    else $error("divide by zero returned data");

endmodule

@@ rtl/qfa_div_cell.sv @@
// One restoring-division cell that retires one quotient bit per cycle unless stalled.
module qfa_div_cell
  import qfa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      stall_i,
  input  qfa_cell_t cell_i,
  output qfa_cell_t cell_o
);

  qfa_cell_t cell_q;
  qfa_cell_t cell_d;
  logic [MagBits:0] shifted;

  always_comb begin
    cell_d  = cell_i;
    shifted = {cell_i.rem[MagBits-1:0], cell_i.num[NumBits-1]};
    cell_d.num = {cell_i.num[NumBits-2:0], 1'b0};
    if (shifted >= {1'b0, cell_i.den}) begin
      cell_d.rem  = shifted - {1'b0, cell_i.den};
      cell_d.quot = {cell_i.quot[QuotBits-2:0], 1'b1};
    end else begin
      cell_d.rem  = shifted;
      cell_d.quot = {cell_i.quot[QuotBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (!stall_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
